>>> rtl/lbbt_pkg.sv
// Shared types and constants for the label bounding box tracker.
package lbbt_pkg;

    localparam int LABEL_COUNT = 256;
    localparam int COORD_BITS  = 12;
    localparam int LABEL_BITS  = $clog2(LABEL_COUNT);

    localparam int DIM_BITS    = 13;
    localparam int LBL_W       = 16;
    localparam int MAXLBL_BITS = 8;
    localparam int MARGIN_BITS = 9;
    localparam int CFG_BITS    = 13;
    localparam int ARITH_BITS  = 15;

    localparam logic [1:0] CFG_NUM_COLS   = 2'd0;
    localparam logic [1:0] CFG_NUM_ROWS   = 2'd1;
    localparam logic [1:0] CFG_MAX_LABEL  = 2'd2;
    localparam logic [1:0] CFG_BOX_MARGIN = 2'd3;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [LBL_W-1:0]  label;
    } t_in_req;

    typedef struct packed {
        logic [LBL_W-1:0]    box_label;
        logic [DIM_BITS-1:0] col_lo;
        logic [DIM_BITS-1:0] row_lo;
        logic [DIM_BITS-1:0] box_width;
        logic [DIM_BITS-1:0] box_height;
        logic                bad_label;
    } t_out_req;

    typedef struct packed {
        logic [COORD_BITS-1:0] col_min;
        logic [COORD_BITS-1:0] col_max;
        logic [COORD_BITS-1:0] row_min;
        logic [COORD_BITS-1:0] row_max;
    } t_box_entry;

    typedef struct packed {
        logic                  en;
        logic [LABEL_BITS-1:0] addr;
        t_box_entry            data;
    } t_store_wr;

endpackage

>>> rtl/lbbt_store.sv
// Label-indexed box memory with valid flags and write-to-read forwarding.
module lbbt_store
    import lbbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_rd_en,
    input  logic [LABEL_BITS-1:0] i_rd_addr,
    input  t_store_wr             i_wr,
    output t_box_entry            o_rd_data,
    output logic                  o_rd_hit
);

    t_box_entry            r_mem [LABEL_COUNT];
    t_box_entry            r_rd_data;
    logic [LABEL_BITS-1:0] r_rd_addr;
    logic                  r_valid [LABEL_COUNT];
    logic                  r_fwd_sel;
    t_box_entry            r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_sel <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_sel <= i_wr.en && (i_wr.addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LABEL_COUNT; i++) begin
            if (!i_rst_n || i_clear) begin
                r_valid[i] <= 1'b0;
            end else if (i_wr.en && (i_wr.addr == LABEL_BITS'(i))) begin
                r_valid[i] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_fwd_sel ? r_fwd_data : r_rd_data;
    assign o_rd_hit  = r_valid[r_rd_addr];

endmodule

>>> rtl/lbbt_scan.sv
// Raster scan position counters.
module lbbt_scan
    import lbbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_clear,
    input  logic [DIM_BITS-1:0]   i_num_cols,
    input  logic [DIM_BITS-1:0]   i_num_rows,
    output logic [COORD_BITS-1:0] o_col,
    output logic [COORD_BITS-1:0] o_row
);

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;
    logic [COORD_BITS:0]   col_inc;
    logic [COORD_BITS:0]   row_inc;

    always_comb begin
        col_inc = {1'b0, r_col} + 1'b1;
        row_inc = {1'b0, r_row} + 1'b1;
        n_col   = r_col;
        n_row   = r_row;
        if (i_clear) begin
            n_col = '0;
            n_row = '0;
        end else if (i_step) begin
            if ((col_inc[COORD_BITS-1:0] == '0) ||
                    (DIM_BITS'(col_inc) >= i_num_cols)) begin
                n_col = '0;
                if ((row_inc[COORD_BITS-1:0] == '0) ||
                        (DIM_BITS'(row_inc) >= i_num_rows)) begin
                    n_row = '0;
                end else begin
                    n_row = row_inc[COORD_BITS-1:0];
                end
            end else begin
                n_col = col_inc[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col = r_col;
    assign o_row = r_row;

endmodule

>>> rtl/lbbt_query.sv
// Margin, clamp and size computation for a box query.
module lbbt_query
    import lbbt_pkg::*;
(
    input  t_box_entry              i_entry,
    input  logic                    i_hit,
    input  logic                    i_bad,
    input  logic [LBL_W-1:0]        i_label,
    input  logic [DIM_BITS-1:0]     i_num_cols,
    input  logic [DIM_BITS-1:0]     i_num_rows,
    input  logic signed [MARGIN_BITS-1:0] i_margin,
    output t_out_req                o_res
);

    logic signed [ARITH_BITS-1:0] margin;
    logic signed [ARITH_BITS-1:0] clo;
    logic signed [ARITH_BITS-1:0] chi;
    logic signed [ARITH_BITS-1:0] rlo;
    logic signed [ARITH_BITS-1:0] rhi;
    logic signed [ARITH_BITS-1:0] ncols;
    logic signed [ARITH_BITS-1:0] nrows;
    logic signed [ARITH_BITS-1:0] wid;
    logic signed [ARITH_BITS-1:0] hgt;

    always_comb begin
        margin = ARITH_BITS'(i_margin);
        ncols  = ARITH_BITS'(i_num_cols);
        nrows  = ARITH_BITS'(i_num_rows);
        clo = ARITH_BITS'(i_entry.col_min) - margin;
        chi = ARITH_BITS'(i_entry.col_max) + margin + 1'sd1;
        rlo = ARITH_BITS'(i_entry.row_min) - margin;
        rhi = ARITH_BITS'(i_entry.row_max) + margin + 1'sd1;
        if (clo < 0) begin
            clo = '0;
        end
        if (rlo < 0) begin
            rlo = '0;
        end
        if (chi > ncols) begin
            chi = ncols;
        end
        if (rhi > nrows) begin
            rhi = nrows;
        end
        wid = chi - clo;
        hgt = rhi - rlo;

        o_res           = '0;
        o_res.box_label = i_label;
        o_res.bad_label = i_bad;
        if (!i_bad && i_hit && (clo < chi) && (rlo < rhi)) begin
            o_res.col_lo     = DIM_BITS'(clo);
            o_res.row_lo     = DIM_BITS'(rlo);
            o_res.box_width  = DIM_BITS'(wid);
            o_res.box_height = DIM_BITS'(hgt);
        end
    end

endmodule

>>> rtl/label_bounding_box_tracker.sv
// Top level of the label bounding box tracker.
// The block takes one request per clock while the output register is free. A request
// reads its label's entry from a 256-entry box memory with a registered read port; the
// entry is then updated and written back, or, for a query or a bad-label pixel, a
// result is formed into the output register. A request whose label matches the one
// written just before it is served from a forwarding register. A clear resets all
// per-label valid flags at once.
// Input requests stall only while the output register holds a result not yet taken.
module label_bounding_box_tracker
    import lbbt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_req             i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_req            o_out_req,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    logic [DIM_BITS-1:0]           r_num_cols;
    logic [DIM_BITS-1:0]           r_num_rows;
    logic [MAXLBL_BITS-1:0]        r_max_label;
    logic signed [MARGIN_BITS-1:0] r_box_margin;

    logic       r_s1_valid;
    t_in_req    r_s1_req;
    logic       r_out_valid;
    t_out_req   r_out_req;

    logic                  advance;
    logic                  s1_bad;
    logic                  s1_pixel;
    logic                  s1_query;
    logic                  s1_clear;
    t_box_entry            rd_entry;
    logic                  rd_hit;
    t_store_wr             wr;
    logic [COORD_BITS-1:0] scan_col;
    logic [COORD_BITS-1:0] scan_row;
    t_out_req              q_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols   <= DIM_BITS'(640);
            r_num_rows   <= DIM_BITS'(480);
            r_max_label  <= '1;
            r_box_margin <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_COLS:   r_num_cols   <= i_cfg_data[DIM_BITS-1:0];
                CFG_NUM_ROWS:   r_num_rows   <= i_cfg_data[DIM_BITS-1:0];
                CFG_MAX_LABEL:  r_max_label  <= i_cfg_data[MAXLBL_BITS-1:0];
                CFG_BOX_MARGIN: r_box_margin <= i_cfg_data[MARGIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance;

    always_comb begin
        s1_pixel = 1'b0;
        s1_query = 1'b0;
        s1_clear = 1'b0;
        case (r_s1_req.cmd)
            CMD_PIXEL: s1_pixel = r_s1_valid;
            CMD_QUERY: s1_query = r_s1_valid;
            CMD_CLEAR: s1_clear = r_s1_valid;
            default: ;
        endcase
        s1_bad = (r_s1_req.label > LBL_W'(r_max_label)) ||
                 ({1'b0, r_s1_req.label} >= (LBL_W+1)'(LABEL_COUNT));
    end

    always_comb begin
        wr.en   = advance && s1_pixel && !s1_bad;
        wr.addr = r_s1_req.label[LABEL_BITS-1:0];
        if (!rd_hit) begin
            wr.data = '{col_min: scan_col, col_max: scan_col,
                        row_min: scan_row, row_max: scan_row};
        end else begin
            wr.data = rd_entry;
            if (scan_col < rd_entry.col_min) begin
                wr.data.col_min = scan_col;
            end
            if (scan_col > rd_entry.col_max) begin
                wr.data.col_max = scan_col;
            end
            if (scan_row < rd_entry.row_min) begin
                wr.data.row_min = scan_row;
            end
            if (scan_row > rd_entry.row_max) begin
                wr.data.row_max = scan_row;
            end
        end
    end

    lbbt_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (advance && s1_clear),
        .i_rd_en   (advance),
        .i_rd_addr (i_in_req.label[LABEL_BITS-1:0]),
        .i_wr      (wr),
        .o_rd_data (rd_entry),
        .o_rd_hit  (rd_hit)
    );

    lbbt_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance && s1_pixel),
        .i_clear    (advance && s1_clear),
        .i_num_cols (r_num_cols),
        .i_num_rows (r_num_rows),
        .o_col      (scan_col),
        .o_row      (scan_row)
    );

    lbbt_query u_query (
        .i_entry    (rd_entry),
        .i_hit      (rd_hit && s1_query),
        .i_bad      (s1_bad),
        .i_label    (r_s1_req.label),
        .i_num_cols (r_num_cols),
        .i_num_rows (r_num_rows),
        .i_margin   (r_box_margin),
        .o_res      (q_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_in_valid;
            r_out_valid <= s1_query || (s1_pixel && s1_bad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_req  <= i_in_req;
            r_out_req <= q_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

>>> rtl/lbbt_checker.sv
// Port-level assertions for the label bounding box tracker and their binding.
module lbbt_checker
    import lbbt_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_req o_out_req
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("Output request changed while stalled.");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled with an empty output register.");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.bad_label |->
            o_out_req.box_width == '0 && o_out_req.box_height == '0 &&
            o_out_req.col_lo == '0 && o_out_req.row_lo == '0)
        else $error("Bad label result carries a box.");

    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.box_width == '0 || o_out_req.box_height == '0) |->
            o_out_req.box_width == '0 && o_out_req.box_height == '0 &&
            o_out_req.col_lo == '0 && o_out_req.row_lo == '0)
        else $error("Empty box is not all zero.");

endmodule

bind label_bounding_box_tracker lbbt_checker u_lbbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);
